// ===== hw/rtl/sida_pkg.sv =====
`default_nettype none
package sida_pkg;

	localparam logic [7:0] CHAR_MINUS = 8'd45;
	localparam logic [7:0] CHAR_ZERO  = 8'd48;

	// Operations of the shared BCD shift unit
	typedef enum logic [1:0] {
		BCD_HOLD,
		BCD_LOAD,
		BCD_DABBLE,
		BCD_DIGIT_SHIFT
	} bcd_op_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sida_bcd_unit.sv =====
`default_nettype none
// Shift-and-add-3 binary to BCD unit; also shifts out one digit at a time.
module sida_bcd_unit #(
	parameter int VALUE_BITS = 32,
	parameter int NDIG       = 10
) (
	input  wire                    clk,
	input  var sida_pkg::bcd_op_t  op,
	input  wire [VALUE_BITS-1:0]   load_mag,
	output logic [3:0]             top_digit
);

	localparam int BCD_BITS = 4 * NDIG;

	logic [VALUE_BITS-1:0] mag_q;
	logic [BCD_BITS-1:0]   bcd_q;
	logic [BCD_BITS-1:0]   adj;

	// Add 3 to every digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i*4 +: 4] >= 4'd5) begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
			end else begin
				adj[i*4 +: 4] = bcd_q[i*4 +: 4];
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			sida_pkg::BCD_LOAD: begin
				mag_q <= load_mag;
				bcd_q <= '0;
			end
			sida_pkg::BCD_DABBLE: begin
				bcd_q <= {adj[BCD_BITS-2:0], mag_q[VALUE_BITS-1]};
				mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
			end
			sida_pkg::BCD_DIGIT_SHIFT: begin
				bcd_q <= {bcd_q[BCD_BITS-5:0], 4'h0};
			end
			sida_pkg::BCD_HOLD: begin
				bcd_q <= bcd_q;
			end
			default: begin
				bcd_q <= bcd_q;
			end
		endcase
	end

	assign top_digit = bcd_q[BCD_BITS-1 -: 4];

endmodule
`default_nettype wire

// ===== hw/rtl/signed_int_to_decimal_ascii_unit.sv =====
// The first character follows the bit-serial BCD conversion (one bit per cycle) and the
// leading-zero digit scan; a new value is accepted only after the last character of the
// previous one has gone out.
// Characters leave one per cycle while the sink is ready; s_tready is low meanwhile.
// Reset: arst_n asynchronous, active low; returns the sequencer to idle, drops output.
`default_nettype none
module signed_int_to_decimal_ascii_unit #(
	parameter int VALUE_BITS = 32
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// input stream
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	input  wire [((VALUE_BITS+7)/8)*8-1:0]      s_tdata,   // [VALUE_BITS-1:0] value
	// output stream
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	output logic [7:0]                          m_tdata,   // [7:0] character
	output logic                                m_tlast    // last_char
);

	// Decimal digits that hold any magnitude up to 2^(VALUE_BITS-1)
	localparam int NDIG     = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int CNT_BITS = $clog2(VALUE_BITS + 1);
	localparam int DIG_BITS = $clog2(NDIG + 1);

	sida_pkg::state_t   state_q, state_d;
	sida_pkg::bcd_op_t  op;
	logic [CNT_BITS-1:0] cnt_q, cnt_d;
	logic [DIG_BITS-1:0] dig_q, dig_d;
	logic                neg_q, neg_d;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [3:0]            top_digit;

	// Magnitude as an unsigned value, so the most negative input stays exact
	assign raw = s_tdata[VALUE_BITS-1:0];
	assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

	sida_bcd_unit #(
		.VALUE_BITS(VALUE_BITS),
		.NDIG      (NDIG)
	) u_bcd (
		.clk      (clk),
		.op       (op),
		.load_mag (mag),
		.top_digit(top_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sida_pkg::ST_IDLE;
			cnt_q   <= '0;
			dig_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			dig_q   <= dig_d;
			neg_q   <= neg_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		dig_d    = dig_q;
		neg_d    = neg_q;
		op       = sida_pkg::BCD_HOLD;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		m_tdata  = sida_pkg::CHAR_ZERO + {4'h0, top_digit};
		m_tlast  = 1'b0;
		unique case (state_q)
			sida_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					// load magnitude, remember the sign, start the bit loop
					op      = sida_pkg::BCD_LOAD;
					neg_d   = raw[VALUE_BITS-1];
					cnt_d   = CNT_BITS'(VALUE_BITS);
					state_d = sida_pkg::ST_CONV;
				end
			end
			sida_pkg::ST_CONV: begin
				// one magnitude bit into the BCD register per cycle
				op    = sida_pkg::BCD_DABBLE;
				cnt_d = cnt_q - 1'b1;
				if (cnt_q == CNT_BITS'(1)) begin
					dig_d   = DIG_BITS'(NDIG);
					state_d = sida_pkg::ST_SKIP;
				end
			end
			sida_pkg::ST_SKIP: begin
				// drop leading zeros, but keep the units digit
				if (top_digit == 4'h0 && dig_q != DIG_BITS'(1)) begin
					op    = sida_pkg::BCD_DIGIT_SHIFT;
					dig_d = dig_q - 1'b1;
				end else if (neg_q) begin
					state_d = sida_pkg::ST_SIGN;
				end else begin
					state_d = sida_pkg::ST_EMIT;
				end
			end
			sida_pkg::ST_SIGN: begin
				m_tvalid = 1'b1;
				m_tdata  = sida_pkg::CHAR_MINUS;
				if (m_tready) begin
					state_d = sida_pkg::ST_EMIT;
				end
			end
			sida_pkg::ST_EMIT: begin
				m_tvalid = 1'b1;
				m_tlast  = (dig_q == DIG_BITS'(1));
				if (m_tready) begin
					// advance to the next digit once this item is taken
					op    = sida_pkg::BCD_DIGIT_SHIFT;
					dig_d = dig_q - 1'b1;
					if (dig_q == DIG_BITS'(1)) begin
						state_d = sida_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sida_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== hw/rtl/sida_checker.sv =====
`default_nettype none
module sida_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       s_tvalid,
	input wire       s_tready,
	input wire       m_tvalid,
	input wire       m_tready,
	input wire [7:0] m_tdata,
	input wire       m_tlast
);

	// A stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
		else $error("stalled output item changed");

	// Never take a number while characters are going out
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output valid");

	// Only a minus sign or a digit goes out
	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata == sida_pkg::CHAR_MINUS ||
			(m_tdata >= sida_pkg::CHAR_ZERO && m_tdata <= sida_pkg::CHAR_ZERO + 8'd9)))
		else $error("output character is not sign or digit");

	// A minus sign is followed at once by a digit, never by end of text
	a_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tdata == sida_pkg::CHAR_MINUS) |->
			(!m_tlast ##1 (m_tvalid && m_tdata != sida_pkg::CHAR_MINUS)))
		else $error("minus sign not followed by a digit");

endmodule

bind signed_int_to_decimal_ascii_unit sida_checker u_sida_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
module tb_top;

	localparam int VALUE_BITS     = 32;
	localparam int DIRECTED_COUNT = 22;
	localparam int RANDOM_COUNT   = 190;
	// Limit for the whole run, not one item; the slowest item has its conversion, 11 characters
	// under the heaviest stall mode and the longest sender gap.
	localparam int CYCLE_LIMIT    = 400000;
	localparam int DRAIN_CYCLES   = 48;

	// One expected character of the output stream
	typedef struct packed {
		logic [7:0] character;
		logic       last_char;
	} ascii_char_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [VALUE_BITS-1:0] s_tdata  = '0;   // [31:0] value
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [7:0]            m_tdata;         // [7:0] character
	logic                  m_tlast;         // last_char

	ascii_char_t pending_chars[$];
	int unsigned mismatch_count = 0;
	int unsigned chars_checked  = 0;
	int unsigned numbers_sent   = 0;
	int unsigned negatives_sent = 0;
	int unsigned cycle_count    = 0;
	int unsigned burst_left     = 0;

	logic [VALUE_BITS-1:0] directed_values[DIRECTED_COUNT];
	string                 directed_texts[DIRECTED_COUNT];

	signed_int_to_decimal_ascii_unit #(
		.VALUE_BITS(VALUE_BITS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog: end the run as failed when cycle_count reaches CYCLE_LIMIT
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d characters still owed", $time,
				pending_chars.size());
			$display("status: fail");
			$finish;
		end
	end

	// Queue the characters of a literal string, marking the final one
	function automatic void expect_text(input string text);
		for (int i = 0; i < text.len(); i++)
			pending_chars.push_back('{character: text[i], last_char: i == text.len() - 1});
	endfunction

	// Predict the decimal text of one value: sign, then digits with no leading zeros.
	// The magnitude stays unsigned, so the most negative value needs no special path.
	function automatic void expect_decimal(input logic [VALUE_BITS-1:0] value);
		logic [VALUE_BITS-1:0] magnitude;
		logic [7:0]            digits[$];
		magnitude = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
		do begin
			digits.push_front(sida_pkg::CHAR_ZERO + 8'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (value[VALUE_BITS-1])
			pending_chars.push_back('{character: sida_pkg::CHAR_MINUS, last_char: 1'b0});
		foreach (digits[i])
			pending_chars.push_back('{character: digits[i], last_char: i == digits.size() - 1});
	endfunction

	// Draw a value: plain random words, numbers of a random digit count,
	// powers of ten and their neighbors, values near both extremes, and small values
	function automatic logic [VALUE_BITS-1:0] pick_value();
		logic [VALUE_BITS-1:0] bound;
		logic [VALUE_BITS-1:0] value;
		int unsigned           kind;
		kind  = $urandom_range(0, 9);
		bound = 1;
		repeat ($urandom_range(1, 9)) bound = bound * 10;
		case (kind)
			0, 1, 2, 3: value = $urandom;
			4, 5, 6:    value = $urandom % bound;
			7:          value = bound + $urandom_range(0, 2) - 1;
			8:          value = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
				: 32'h7FFF_FFFF - $urandom_range(0, 3);
			default:    value = $urandom_range(0, 20);
		endcase
		// Flip the sign on the bounded kinds half of the time
		if (kind >= 4 && kind != 8 && $urandom_range(0, 1))
			value = ~value + 1'b1;
		return value;
	endfunction

	// Offer one value; between bursts drop tvalid for a random gap and put junk on tdata
	task automatic send_value(input logic [VALUE_BITS-1:0] value, input string text);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			s_tdata  <= $urandom;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 50) : $urandom_range(1, 4))
				@(posedge clk);
			burst_left = $urandom_range(0, 4) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 5);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		numbers_sent++;
		if (value[VALUE_BITS-1])
			negatives_sent++;
		if (text.len() != 0)
			expect_text(text);
		else
			expect_decimal(value);
	endtask

	// Receiver stalls: each stretch picks always-ready, a rotating mask, or random drops
	logic [31:0] stall_mask  = '1;
	logic [1:0]  stall_mode  = '0;
	int unsigned stall_left  = 0;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= 2'($urandom_range(0, 2));
			stall_mask <= $urandom;
			stall_left <= $urandom_range(20, 120);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			2'd0:    m_tready <= 1'b1;
			2'd1:    m_tready <= stall_mask[stall_left[4:0]];
			default: m_tready <= $urandom_range(0, 3) != 0;
		endcase
	end

	// Check every accepted character against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, got %0d '%c' last %0b",
					$time, m_tdata, m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				if (m_tdata !== pending_chars[0].character ||
						m_tlast !== pending_chars[0].last_char) begin
					$display("%0t: mismatch: expected %0d '%c' last %0b, got %0d '%c' last %0b",
						$time, pending_chars[0].character, pending_chars[0].character,
						pending_chars[0].last_char, m_tdata, m_tdata, m_tlast);
					mismatch_count++;
				end
				void'(pending_chars.pop_front());
				chars_checked++;
			end
		end
	end

	initial begin
		// Text is typed in where it is obvious; empty rows go through the predictor
		directed_values = '{
			32'd0, 32'd1, -32'sd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
			32'd9, 32'd10, -32'sd9, -32'sd10, 32'd99, 32'd100,
			32'd999_999_999, 32'd1_000_000_000, -32'sd1_000_000_000, 32'h5555_5555,
			32'hAAAA_AAAA, 32'd12345, -32'sd54321, 32'd4096,
			32'h7FFF_FFFE, 32'hFFFF_FFFE
		};
		directed_texts = '{
			"0", "1", "-1", "2147483647", "-2147483648", "-2147483647",
			"9", "10", "-9", "-10", "", "",
			"", "", "", "",
			"", "", "", "",
			"", "-2"
		};

		// Hold reset, then release it on a rising edge
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIRECTED_COUNT; i++)
			send_value(directed_values[i], directed_texts[i]);
		repeat (RANDOM_COUNT)
			send_value(pick_value(), "");
		s_tvalid <= 1'b0;

		// Drain, then give the block time to show any stray character
		while (pending_chars.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending_chars.size() != 0) begin
			$display("%0t: %0d characters never arrived", $time, pending_chars.size());
			mismatch_count++;
		end

		$display("converted %0d numbers (%0d negative, extremes and powers of ten included)",
			numbers_sent, negatives_sent);
		$display("checked %0d characters under bursty input and stalled output, %0d mismatches",
			chars_checked, mismatch_count);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
hw/rtl/sida_pkg.sv
hw/rtl/sida_bcd_unit.sv
hw/rtl/signed_int_to_decimal_ascii_unit.sv
hw/rtl/sida_checker.sv
sim/tb_top.sv
